/* hw/rtl/unsorted_priority_queue_unit_macros.svh */
// Assertion macros used by the priority queue top level.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef UNSORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define UNSORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define UPQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("upq assertion failed");
// Condition in one cycle that implies a consequence in the next cycle.
`define UPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("upq assertion failed");
`else
`define UPQ_ASSERT(label, clk, rstn, prop)
`define UPQ_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* hw/rtl/upq_pkg.sv */
// Types and constants of the unsorted priority queue.
// Used by upq_scan and unsorted_priority_queue_unit; depends on nothing.
`timescale 1ns / 1ps

package upq_pkg;

    // Operation selector carried in the input word.
    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_CHG = 2'd2,
        CMD_CLR = 2'd3
    } cmd_t;

    // Result status codes.
    localparam logic [2:0] STS_OK          = 3'd0;
    localparam logic [2:0] STS_EMPTY       = 3'd1;
    localparam logic [2:0] STS_FULL        = 3'd2;
    localparam logic [2:0] STS_NOT_FOUND   = 3'd3;
    localparam logic [2:0] STS_MORE_URGENT = 3'd4;

    // Head priority reported for an empty queue.
    localparam logic signed [31:0] EMPTY_PRIO = -32'sd987654321;

    // Width of the entry count field in the result word.
    localparam int ENTRY_W = 5;

    // Control of the shared scan unit.
    typedef struct packed {
        logic start;       // clear the running result and latch the mode
        logic mode_match;  // 1: first tag match, 0: most urgent entry
        logic vld;         // a slot read is presented this cycle
    } scan_ctl_t;

    // Running result of the scan unit.
    typedef struct packed {
        logic               found;
        logic [31:0]        tag;
        logic signed [31:0] prio;
    } scan_res_t;

endpackage

/* hw/rtl/unsorted_priority_queue_unit.sv */
// Top level of the unsorted priority queue: command sequencer, slot memory
// and result register. Depends on upq_pkg, upq_scan and the macros header.
`timescale 1ns / 1ps
//
// Channel   Dir  Payload
// s_        in   s_tuser: cmd; s_tdata: tag, prio
// m_        out  m_tuser: status, is_empty; m_tdata: removed_tag, head_tag,
//                head_prio, entry_total
//
// One word is handled at a time; s_tready is high only while the sequencer idles.
// Each scan reads the held slots in turn through the single memory read port
// and the shared compare unit. Enqueue, clear and a dequeue on an empty queue
// take one head scan, change priority a tag scan and a head scan, dequeue a
// minimum scan, a shift of the later slots and a head scan.
// Reset empties the queue at once; the slot memory is not cleared. A stalled
// result waits in the output register and holds the sequencer at the end.

`include "unsorted_priority_queue_unit_macros.svh"

module unsorted_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [31:0] tag, [63:32] prio
    input  logic [1:0]   s_tuser,   // [1:0] cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [31:0] removed_tag, [63:32] head_tag,
                                    // [95:64] head_prio, [100:96] entry_total
    output logic [3:0]   m_tuser    // [2:0] status, [3] is_empty
);
    import upq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_MOVE,
        S_HEAD
    } state_t;

    state_t             state_reg;
    cmd_t               cmd_reg;
    logic [31:0]        tag_reg;
    logic signed [31:0] prio_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [2:0]         status_reg;
    logic [31:0]        removed_reg;

    // Slot memory with a registered read port.
    logic [31:0]        mem_tag [CAPACITY];
    logic signed [31:0] mem_prio [CAPACITY];
    logic [31:0]        rd_tag_reg;
    logic signed [31:0] rd_prio_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_vld_reg;

    // Result register.
    logic               m_tvalid_reg;
    logic [2:0]         m_status_reg;
    logic [31:0]        m_removed_reg;
    logic [31:0]        m_head_tag_reg;
    logic signed [31:0] m_head_prio_reg;
    logic [ENTRY_W-1:0] m_total_reg;
    logic               m_empty_reg;

    logic               in_fire;
    cmd_t               in_cmd;
    logic [31:0]        in_tag;
    logic signed [31:0] in_prio;
    logic               busy_pass;
    logic               rd_issue;
    logic               pass_done;
    logic               out_free;
    logic               out_load;
    logic               is_full;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [31:0]        wr_tag;
    logic signed [31:0] wr_prio;
    scan_ctl_t          scan_ctl;
    scan_res_t          scan_res;
    logic [IDX_W-1:0]   best_idx;

    assign in_cmd   = cmd_t'(s_tuser[1:0]);
    assign in_tag   = s_tdata[31:0];
    assign in_prio  = s_tdata[63:32];
    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_full  = (cnt_reg == CNT_W'(CAPACITY));

    // A pass reads slots idx_reg .. cnt_reg - 1, one per cycle.
    assign busy_pass = (state_reg == S_FIND) || (state_reg == S_MOVE)
                       || (state_reg == S_HEAD);
    assign rd_issue  = busy_pass && (idx_reg < cnt_reg);
    assign pass_done = !rd_issue && !rd_vld_reg;

    // The result word is loaded once the head scan is over and the slot is free.
    assign out_load = (state_reg == S_HEAD) && pass_done && out_free;

    // Scan unit control: restart on every pass that uses it.
    always_comb begin
        scan_ctl.start      = 1'b0;
        scan_ctl.mode_match = 1'b0;
        scan_ctl.vld        = rd_vld_reg
                              && ((state_reg == S_FIND) || (state_reg == S_HEAD));
        if (in_fire) begin
            scan_ctl.start      = 1'b1;
            scan_ctl.mode_match = (in_cmd == CMD_CHG);
        end else if ((state_reg == S_FIND) && pass_done
                     && !((cmd_reg == CMD_DEQ) && scan_res.found)) begin
            scan_ctl.start = 1'b1;
        end else if ((state_reg == S_MOVE) && pass_done) begin
            scan_ctl.start = 1'b1;
        end
    end

    upq_scan #(
        .IDX_W(IDX_W)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (scan_ctl),
        .key_tag  (tag_reg),
        .rd_tag   (rd_tag_reg),
        .rd_prio  (rd_prio_reg),
        .rd_idx   (rd_idx_reg),
        .res      (scan_res),
        .best_idx (best_idx)
    );

    // Memory write source: append, priority update, or shift down one slot.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[IDX_W-1:0];
        wr_tag  = in_tag;
        wr_prio = in_prio;
        unique case (state_reg)
            S_IDLE: begin
                wr_en = in_fire && (in_cmd == CMD_ENQ) && !is_full;
            end
            S_FIND: begin
                wr_en   = pass_done && (cmd_reg == CMD_CHG) && scan_res.found
                          && !(scan_res.prio < prio_reg);
                wr_addr = best_idx;
                wr_tag  = scan_res.tag;
                wr_prio = prio_reg;
            end
            S_MOVE: begin
                wr_en   = rd_vld_reg;
                wr_addr = rd_idx_reg - IDX_W'(1);
                wr_tag  = rd_tag_reg;
                wr_prio = rd_prio_reg;
            end
            S_HEAD: begin
                wr_en = 1'b0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Slot memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_tag[wr_addr]  <= wr_tag;
            mem_prio[wr_addr] <= wr_prio;
        end
        if (rd_issue) begin
            rd_tag_reg  <= mem_tag[idx_reg[IDX_W-1:0]];
            rd_prio_reg <= mem_prio[idx_reg[IDX_W-1:0]];
            rd_idx_reg  <= idx_reg[IDX_W-1:0];
        end
    end

    // Sequencer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_issue;
            if (rd_issue) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        cmd_reg     <= in_cmd;
                        tag_reg     <= in_tag;
                        prio_reg    <= in_prio;
                        removed_reg <= '0;
                        idx_reg     <= '0;
                        unique case (in_cmd)
                            CMD_ENQ: begin
                                state_reg <= S_HEAD;
                                if (is_full) begin
                                    status_reg <= STS_FULL;
                                end else begin
                                    status_reg <= STS_OK;
                                    cnt_reg    <= cnt_reg + CNT_W'(1);
                                end
                            end
                            CMD_DEQ: begin
                                if (cnt_reg == '0) begin
                                    status_reg <= STS_EMPTY;
                                    state_reg  <= S_HEAD;
                                end else begin
                                    status_reg <= STS_OK;
                                    state_reg  <= S_FIND;
                                end
                            end
                            CMD_CHG: begin
                                status_reg <= STS_OK;
                                state_reg  <= S_FIND;
                            end
                            CMD_CLR: begin
                                status_reg <= STS_OK;
                                cnt_reg    <= '0;
                                state_reg  <= S_HEAD;
                            end
                            default: begin
                                status_reg <= STS_OK;
                                state_reg  <= S_HEAD;
                            end
                        endcase
                    end
                end
                S_FIND: begin
                    if (pass_done) begin
                        if (cmd_reg == CMD_DEQ) begin
                            // Remove the head, then shift the later slots down.
                            removed_reg <= scan_res.tag;
                            idx_reg     <= CNT_W'(best_idx) + CNT_W'(1);
                            state_reg   <= S_MOVE;
                        end else begin
                            idx_reg   <= '0;
                            state_reg <= S_HEAD;
                            if (!scan_res.found) begin
                                status_reg <= STS_NOT_FOUND;
                            end else if (scan_res.prio < prio_reg) begin
                                status_reg <= STS_MORE_URGENT;
                            end
                        end
                    end
                end
                S_MOVE: begin
                    if (pass_done) begin
                        cnt_reg   <= cnt_reg - CNT_W'(1);
                        idx_reg   <= '0;
                        state_reg <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    if (out_load) begin
                        m_status_reg  <= status_reg;
                        m_removed_reg <= removed_reg;
                        m_total_reg   <= ENTRY_W'(cnt_reg);
                        if (cnt_reg == '0) begin
                            m_head_tag_reg  <= '0;
                            m_head_prio_reg <= EMPTY_PRIO;
                            m_empty_reg     <= 1'b1;
                        end else begin
                            m_head_tag_reg  <= scan_res.tag;
                            m_head_prio_reg <= scan_res.prio;
                            m_empty_reg     <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_total_reg, m_head_prio_reg, m_head_tag_reg, m_removed_reg};
    assign m_tuser  = {m_empty_reg, m_status_reg};

    // Checks on the sequencer and the result register.
    `UPQ_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_W'(CAPACITY))
    `UPQ_ASSERT(a_idle_no_read, aclk, aresetn, (state_reg != S_IDLE) || !rd_vld_reg)
    `UPQ_ASSERT(a_empty_total, aclk, aresetn,
                !m_tvalid_reg || (m_empty_reg == (m_total_reg == '0)))
    `UPQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_fire, !s_tready)
    `UPQ_ASSERT_NEXT(a_deq_removes, aclk, aresetn,
                     (state_reg == S_MOVE) && pass_done, cnt_reg == $past(cnt_reg) - CNT_W'(1))

endmodule

/* hw/rtl/upq_scan.sv */
// Shared compare unit of the priority queue: one slot per cycle, keeps the
// most urgent entry or the first tag match. Depends on upq_pkg.
`timescale 1ns / 1ps

module upq_scan #(
    parameter int IDX_W = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  upq_pkg::scan_ctl_t ctl,
    input  logic [31:0]        key_tag,
    input  logic [31:0]        rd_tag,
    input  logic signed [31:0] rd_prio,
    input  logic [IDX_W-1:0]   rd_idx,
    output upq_pkg::scan_res_t res,
    output logic [IDX_W-1:0]   best_idx
);
    import upq_pkg::*;

    logic               found_reg;
    logic               mode_reg;
    logic [31:0]        tag_reg;
    logic signed [31:0] prio_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               hit;

    // A more urgent slot replaces the best one; on equal priority the lower tag
    // wins, so the earliest of fully equal entries is kept. In match mode only the first hit counts.
    always_comb begin
        if (mode_reg) begin
            hit = !found_reg && (rd_tag == key_tag);
        end else begin
            hit = !found_reg || (rd_prio < prio_reg)
                  || ((rd_prio == prio_reg) && (rd_tag < tag_reg));
        end
    end

    // Running result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            mode_reg  <= 1'b0;
        end else if (ctl.start) begin
            found_reg <= 1'b0;
            mode_reg  <= ctl.mode_match;
        end else if (ctl.vld && hit) begin
            found_reg <= 1'b1;
        end
        if (aresetn && !ctl.start && ctl.vld && hit) begin
            tag_reg  <= rd_tag;
            prio_reg <= rd_prio;
            idx_reg  <= rd_idx;
        end
    end

    assign res.found = found_reg;
    assign res.tag   = tag_reg;
    assign res.prio  = prio_reg;
    assign best_idx  = idx_reg;

endmodule

/* test/unsorted_priority_queue_unit_tb.sv */
// Self-checking testbench for unsorted_priority_queue_unit: drives command words,
// mirrors the queue in a scoreboard class and checks every result word.
// Depends on upq_pkg and the unsorted_priority_queue_unit RTL.
`timescale 1ns / 1ps

module unsorted_priority_queue_unit_tb;

    import upq_pkg::*;

    localparam int QCAP = 16;
    localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] PRIO_MAX = 32'sh7FFF_FFFF;

    // One result word split into its fields.
    typedef struct {
        logic [2:0]         status;
        logic [31:0]        removed_tag;
        logic [31:0]        head_tag;
        logic signed [31:0] head_prio;
        logic [4:0]         entry_total;
        logic               is_empty;
    } upq_result_t;

    // Mirror of the queue contents and the store of predicted result words.
    class queue_mirror;
        logic [31:0]        slot_tag[QCAP];
        logic signed [31:0] slot_prio[QCAP];
        int                 held;
        int                 errors;
        upq_result_t        predicted_words[$];

        function new();
            held = 0;
            errors = 0;
        endfunction

        // True when slot a beats slot b: lower priority first, then lower tag.
        function bit beats(int a, int b);
            if (slot_prio[a] != slot_prio[b])
                return slot_prio[a] < slot_prio[b];
            return slot_tag[a] < slot_tag[b];
        endfunction

        function int head_slot();
            int best;
            best = 0;
            for (int i = 1; i < held; i++)
                if (beats(i, best))
                    best = i;
            return best;
        endfunction

        function logic [31:0] pick_held_tag();
            return slot_tag[$urandom_range(0, held - 1)];
        endfunction

        function int pending();
            return predicted_words.size();
        endfunction

        // Applies one accepted command and stores the word it must produce.
        function void apply_command(cmd_t cmd, logic [31:0] tag, logic signed [31:0] prio);
            upq_result_t r;
            int h;
            r.status = STS_OK;
            r.removed_tag = '0;
            case (cmd)
                CMD_ENQ: begin
                    if (held >= QCAP) begin
                        r.status = STS_FULL;
                    end else begin
                        slot_tag[held] = tag;
                        slot_prio[held] = prio;
                        held++;
                    end
                end
                CMD_DEQ: begin
                    if (held == 0) begin
                        r.status = STS_EMPTY;
                    end else begin
                        h = head_slot();
                        r.removed_tag = slot_tag[h];
                        // Later entries close the gap and keep arrival order.
                        for (int i = h; i + 1 < held; i++) begin
                            slot_tag[i] = slot_tag[i + 1];
                            slot_prio[i] = slot_prio[i + 1];
                        end
                        held--;
                    end
                end
                CMD_CHG: begin
                    r.status = STS_NOT_FOUND;
                    for (int i = 0; i < held; i++) begin
                        if (slot_tag[i] == tag) begin
                            if (slot_prio[i] < prio) begin
                                r.status = STS_MORE_URGENT;
                            end else begin
                                slot_prio[i] = prio;
                                r.status = STS_OK;
                            end
                            break;
                        end
                    end
                end
                default: begin
                    held = 0;
                end
            endcase
            if (held == 0) begin
                r.head_tag = '0;
                r.head_prio = EMPTY_PRIO;
                r.is_empty = 1'b1;
            end else begin
                h = head_slot();
                r.head_tag = slot_tag[h];
                r.head_prio = slot_prio[h];
                r.is_empty = 1'b0;
            end
            r.entry_total = held[4:0];
            predicted_words.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Checks one accepted result word against the oldest prediction.
        function void check_word(logic [103:0] data, logic [3:0] user);
            upq_result_t r;
            if (predicted_words.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none, actual %h / %h",
                         $time, data, user);
                errors++;
                return;
            end
            r = predicted_words.pop_front();
            compare_field("status", 32'(r.status), 32'(user[2:0]));
            compare_field("is_empty", 32'(r.is_empty), 32'(user[3]));
            compare_field("removed_tag", r.removed_tag, data[31:0]);
            compare_field("head_tag", r.head_tag, data[63:32]);
            compare_field("head_prio", r.head_prio, data[95:64]);
            compare_field("entry_total", 32'(r.entry_total), 32'(data[100:96]));
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // [31:0] tag, [63:32] prio
    logic [1:0]   s_tuser;   // [1:0] cmd
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;   // [31:0] removed_tag, [63:32] head_tag,
                             // [95:64] head_prio, [100:96] entry_total
    logic [3:0]   m_tuser;   // [2:0] status, [3] is_empty

    queue_mirror mirror = new();
    bit          idle_on;
    int          words_seen;
    int          hold_left;
    int          stall_left;

    unsorted_priority_queue_unit #(
        .CAPACITY(QCAP)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // 100 MHz clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Small pool for matches and duplicates, extremes, and fully random tags.
    function logic [31:0] rand_tag();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(0, 11);
        if (r < 75)
            return (r & 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
        return $urandom();
    endfunction

    function logic signed [31:0] rand_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $signed($urandom_range(0, 8)) - 4;
        if (r < 55) begin
            case ($urandom_range(0, 3))
                0: return PRIO_MIN;
                1: return PRIO_MIN + 1;
                2: return PRIO_MAX - 1;
                default: return PRIO_MAX;
            endcase
        end
        return $signed($urandom());
    endfunction

    // Offers one command word and waits until the block takes it.
    task automatic push_command(cmd_t cmd, logic [31:0] tag, logic signed [31:0] prio);
        int gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = cmd;
        s_tdata = {prio, tag};
        do
            @(posedge aclk);
        while (!s_tready);
        mirror.apply_command(cmd, tag, prio);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // One random command; kind 0 favors enqueue, kind 1 dequeue, kind 2 is mixed.
    task automatic push_random(int kind);
        int r;
        int w_enq;
        int w_deq;
        int w_chg;
        logic [31:0] tag;
        w_enq = (kind == 0) ? 78 : (kind == 1) ? 20 : 40;
        w_deq = (kind == 0) ? 8 : (kind == 1) ? 55 : 30;
        w_chg = (kind == 0) ? 12 : (kind == 1) ? 23 : 27;
        r = $urandom_range(0, 99);
        if (r < w_enq) begin
            push_command(CMD_ENQ, rand_tag(), rand_prio());
        end else if (r < w_enq + w_deq) begin
            push_command(CMD_DEQ, rand_tag(), rand_prio());
        end else if (r < w_enq + w_deq + w_chg) begin
            // Mostly aim at a tag that is actually held.
            if (mirror.held > 0 && $urandom_range(0, 99) < 70)
                tag = mirror.pick_held_tag();
            else
                tag = rand_tag();
            push_command(CMD_CHG, tag, rand_prio());
        end else begin
            push_command(CMD_CLR, rand_tag(), rand_prio());
        end
    endtask

    // Result side: random stalls plus one long hold-off that backs up the input.
    initial begin
        m_tready = 1'b0;
        words_seen = 0;
        hold_left = 0;
        stall_left = 0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                stall_left = pick_gap();
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                mirror.check_word(m_tdata, m_tuser);
                words_seen++;
                if (words_seen == 120)
                    hold_left = 500;
            end
        end
    end

    // Main sequence: reset, directed commands, random phases, drain and verdict.
    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_ENQ;
        idle_on = 1'b1;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Operations on an empty queue.
        push_command(CMD_DEQ, 32'd0, 32'sd0);
        push_command(CMD_CHG, 32'd5, 32'sd1);
        push_command(CMD_CLR, 32'd0, 32'sd0);
        // All priorities at the maximum: the smallest tag leads.
        push_command(CMD_ENQ, 32'hFFFF_FFFF, PRIO_MAX);
        push_command(CMD_ENQ, 32'd0, PRIO_MAX);
        push_command(CMD_ENQ, 32'd5, PRIO_MAX);
        push_command(CMD_DEQ, 32'd0, 32'sd0);
        // Change priority: accepted, already more urgent, equal, and absent tag.
        push_command(CMD_CHG, 32'hFFFF_FFFF, PRIO_MIN);
        push_command(CMD_CHG, 32'hFFFF_FFFF, 32'sd0);
        push_command(CMD_CHG, 32'hFFFF_FFFF, PRIO_MIN);
        push_command(CMD_CHG, 32'd7, 32'sd3);
        // Duplicate entries: the earliest goes first and the rest keep order.
        push_command(CMD_ENQ, 32'd5, PRIO_MAX);
        push_command(CMD_ENQ, 32'd9, -32'sd1);
        push_command(CMD_DEQ, 32'd0, 32'sd0);
        push_command(CMD_DEQ, 32'd0, 32'sd0);
        push_command(CMD_CHG, 32'd5, 32'sd100);
        push_command(CMD_DEQ, 32'd0, 32'sd0);
        push_command(CMD_CHG, 32'd5, 32'sd100);
        push_command(CMD_ENQ, 32'h8000_0000, PRIO_MIN);
        push_command(CMD_CLR, 32'hFFFF_FFFF, PRIO_MAX);

        // Random phases; the first fills the queue past capacity.
        for (int ph = 0; ph < 10; ph++) begin
            idle_on = (ph % 4 != 1);
            for (int n = 0; n < 55; n++)
                push_random(ph % 3);
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (mirror.pending() != 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
        if (mirror.errors == 0)
            $display("[unsorted_priority_queue_unit] OK");
        else
            $display("[unsorted_priority_queue_unit] ERROR");
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        #10_000_000;
        $display("[unsorted_priority_queue_unit] ERROR");
        $finish;
    end

endmodule
